@@ design/rsc_pkg.sv @@
// rsc_pkg: shared constants for the rpn stack calculator
// token codes, status codes and datapath widths; no dependencies
`timescale 1ns / 1ps

package rsc_pkg;

  // datapath and field widths
  localparam int DATA_W   = 32;
  localparam int FUNC_W   = 4;
  localparam int STATUS_W = 2;

  // default stack bound
  localparam int STACK_DEPTH_DEF = 16;

  // iterative multiply and divide take one bit per step
  localparam int STEP_W = $clog2(DATA_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DATA_W - 1);

  // token codes
  localparam logic [FUNC_W-1:0] FN_PUSH = 4'd0;
  localparam logic [FUNC_W-1:0] FN_ADD  = 4'd1;
  localparam logic [FUNC_W-1:0] FN_SUB  = 4'd2;
  localparam logic [FUNC_W-1:0] FN_MUL  = 4'd3;
  localparam logic [FUNC_W-1:0] FN_DIV  = 4'd4;
  localparam logic [FUNC_W-1:0] FN_SWAP = 4'd5;
  localparam logic [FUNC_W-1:0] FN_DUP  = 4'd6;
  localparam logic [FUNC_W-1:0] FN_EQ   = 4'd7;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SHOWN = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ERROR = 2'd2;

endpackage

@@ design/rsc_ram.sv @@
// rsc_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module rsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/rpn_stack_calculator.sv @@
// rpn_stack_calculator: reverse-polish integer calculator on a bounded stack
// uses rsc_pkg and one rsc_ram instance for the entries below the top
//
//   channel | signals                            | direction
//   --------+------------------------------------+----------
//   in      | in_valid, in_ready, func, push_value | to block
//   out     | out_valid, out_ready, status, shown_value | from block
//
// push, dup, equals and each error but a zero divisor end in the accept cycle.
// add, sub and swap go through accept, ram read of the second entry, finish.
// mul and div run one bit per cycle through the one shared 34-bit adder
// (div adds magnitude steps S_ABSN, S_ABSD and the sign fix-up S_FIX).
// one item at a time; in_ready is low while an item is at work or while a
// finished result cannot move into the output register. reset empties the
// stack; the ram holds no reset value and is never cleared.
`timescale 1ns / 1ps

module rpn_stack_calculator #(
  parameter int STACK_DEPTH = rsc_pkg::STACK_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [rsc_pkg::FUNC_W-1:0]          func,
  input  logic signed [rsc_pkg::DATA_W-1:0]   push_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rsc_pkg::STATUS_W-1:0]        status,
  output logic signed [rsc_pkg::DATA_W-1:0]   shown_value
);

  import rsc_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int SW = DATA_W + 2;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_READ = 8'b0000_0010,
    S_ABSN = 8'b0000_0100,
    S_ABSD = 8'b0000_1000,
    S_DIV  = 8'b0001_0000,
    S_FIX  = 8'b0010_0000,
    S_MUL  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  logic [CW-1:0]       count, count_next;
  logic [DATA_W-1:0]   top, top_next;
  logic [FUNC_W-1:0]   opcode, opcode_next;
  logic [DATA_W-1:0]   acc, acc_next;
  logic [DATA_W-1:0]   aux, aux_next;
  logic [DATA_W-1:0]   opnd, opnd_next;
  logic [STEP_W-1:0]   step, step_next;
  logic                neg, neg_next;
  logic [STATUS_W-1:0] pend_status, pend_status_next;
  logic                out_valid_next;
  logic [STATUS_W-1:0] status_next;
  logic [DATA_W-1:0]   shown_value_next;

  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [DATA_W-1:0] wr_data, rd_data;

  logic [CW-1:0] cnt_m1, cnt_m2;
  logic          full, out_free, accept;

  // shared adder/subtractor
  logic [SW-1:0] add_a, add_b, add_sum;
  logic          add_sub;

  assign add_sum = add_a + (add_b ^ {SW{add_sub}}) + SW'(add_sub);

  assign cnt_m1   = count - CW'(1);
  assign cnt_m2   = count - CW'(2);
  assign full     = (count == CW'(STACK_DEPTH));
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  // entries below the top of stack
  rsc_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // sequencer and datapath next values
  always_comb begin
    state_next       = state;
    count_next       = count;
    top_next         = top;
    opcode_next      = opcode;
    acc_next         = acc;
    aux_next         = aux;
    opnd_next        = opnd;
    step_next        = step;
    neg_next         = neg;
    pend_status_next = pend_status;
    out_valid_next   = out_valid && !out_ready;
    status_next      = status;
    shown_value_next = shown_value;
    wr_en            = 1'b0;
    wr_addr          = cnt_m1[AW-1:0];
    wr_data          = top;
    rd_en            = 1'b0;
    rd_addr          = cnt_m2[AW-1:0];
    add_a            = '0;
    add_b            = '0;
    add_sub          = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          opcode_next      = func;
          out_valid_next   = 1'b1;
          status_next      = ST_ERROR;
          shown_value_next = '0;
          unique case (func) inside
            FN_PUSH: begin
              if (full) begin
                count_next = '0;
              end else begin
                wr_en       = (count != '0);
                top_next    = push_value;
                count_next  = count + CW'(1);
                status_next = ST_DONE;
              end
            end
            FN_DUP: begin
              if (full || count == '0) begin
                count_next = '0;
              end else begin
                wr_en       = 1'b1;
                count_next  = count + CW'(1);
                status_next = ST_DONE;
              end
            end
            FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_SWAP: begin
              if (count < CW'(2)) begin
                count_next = '0;
              end else begin
                // second entry comes out of the ram next cycle
                rd_en          = 1'b1;
                out_valid_next = 1'b0;
                state_next     = S_READ;
              end
            end
            FN_EQ: begin
              count_next = '0;
              if (count == CW'(1)) begin
                status_next      = ST_SHOWN;
                shown_value_next = top;
              end
            end
            default: begin
              count_next = '0;
            end
          endcase
        end
      end

      S_READ: begin
        pend_status_next = ST_DONE;
        state_next       = S_DONE;
        unique case (opcode) inside
          FN_SWAP: begin
            wr_en    = 1'b1;
            wr_addr  = cnt_m2[AW-1:0];
            top_next = rd_data;
          end
          FN_ADD, FN_SUB: begin
            add_a      = {2'b00, rd_data};
            add_b      = {2'b00, top};
            add_sub    = (opcode == FN_SUB);
            top_next   = add_sum[DATA_W-1:0];
            count_next = cnt_m1;
          end
          FN_MUL: begin
            acc_next   = '0;
            aux_next   = top;
            opnd_next  = rd_data;
            step_next  = '0;
            state_next = S_MUL;
          end
          FN_DIV: begin
            if (top == '0) begin
              count_next       = '0;
              pend_status_next = ST_ERROR;
            end else begin
              neg_next   = rd_data[DATA_W-1] ^ top[DATA_W-1];
              aux_next   = rd_data;
              opnd_next  = top;
              state_next = S_ABSN;
            end
          end
          default: begin
            count_next       = '0;
            pend_status_next = ST_ERROR;
          end
        endcase
      end

      // magnitude of the dividend
      S_ABSN: begin
        add_b      = {2'b00, aux};
        add_sub    = aux[DATA_W-1];
        aux_next   = add_sum[DATA_W-1:0];
        state_next = S_ABSD;
      end

      // magnitude of the divisor
      S_ABSD: begin
        add_b      = {2'b00, opnd};
        add_sub    = opnd[DATA_W-1];
        opnd_next  = add_sum[DATA_W-1:0];
        acc_next   = '0;
        step_next  = '0;
        state_next = S_DIV;
      end

      // restoring divide step: acc holds the remainder, aux the quotient
      S_DIV: begin
        add_a    = {1'b0, acc, aux[DATA_W-1]};
        add_b    = {2'b00, opnd};
        add_sub  = 1'b1;
        if (!add_sum[SW-1]) begin
          acc_next = add_sum[DATA_W-1:0];
        end else begin
          acc_next = {acc[DATA_W-2:0], aux[DATA_W-1]};
        end
        aux_next  = {aux[DATA_W-2:0], !add_sum[SW-1]};
        step_next = step + STEP_W'(1);
        if (step == LAST_STEP) begin
          state_next = S_FIX;
        end
      end

      // floor correction: negative quotient is ~q, or ~q + 1 when exact
      S_FIX: begin
        add_a            = {2'b00, neg ? ~aux : aux};
        add_b            = SW'(neg && acc == '0);
        top_next         = add_sum[DATA_W-1:0];
        count_next       = cnt_m1;
        pend_status_next = ST_DONE;
        state_next       = S_DONE;
      end

      // shift-add multiply, multiplier msb first
      S_MUL: begin
        add_a     = {2'b00, acc[DATA_W-2:0], 1'b0};
        add_b     = {2'b00, aux[DATA_W-1] ? opnd : '0};
        acc_next  = add_sum[DATA_W-1:0];
        aux_next  = {aux[DATA_W-2:0], 1'b0};
        step_next = step + STEP_W'(1);
        if (step == LAST_STEP) begin
          top_next         = add_sum[DATA_W-1:0];
          count_next       = cnt_m1;
          pend_status_next = ST_DONE;
          state_next       = S_DONE;
        end
      end

      // hand the result to the output register
      S_DONE: begin
        if (out_free) begin
          out_valid_next   = 1'b1;
          status_next      = pend_status;
          shown_value_next = '0;
          state_next       = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    top         <= top_next;
    opcode      <= opcode_next;
    acc         <= acc_next;
    aux         <= aux_next;
    opnd        <= opnd_next;
    step        <= step_next;
    neg         <= neg_next;
    pend_status <= pend_status_next;
    status      <= status_next;
    shown_value <= shown_value_next;
  end

endmodule

@@ tb/testbench.sv @@
// testbench: self-checking bench for the rpn_stack_calculator block
// depends on rsc_pkg for token and status codes and on the block itself
`timescale 1ns / 1ps

module testbench;
  import rsc_pkg::*;

  // token codes the package leaves out: all of them are invalid tokens
  localparam logic [FUNC_W-1:0] FN_BAD      = 4'd8;
  localparam logic [FUNC_W-1:0] FN_BAD_LAST = 4'd15;

  localparam int LIMIT_NS = 10_000_000;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   value;
  } calc_result_t;

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  logic [FUNC_W-1:0]          func;
  logic signed [DATA_W-1:0]   push_value;
  logic                       out_valid;
  logic                       out_ready;
  logic [STATUS_W-1:0]        status;
  logic signed [DATA_W-1:0]   shown_value;

  // predicted stack contents and the results still owed by the block
  logic [DATA_W-1:0] calc_stack [STACK_DEPTH_DEF];
  int                calc_depth;
  calc_result_t      calc_expect [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned stall_len;
  int unsigned stall_tag;
  int unsigned stall_seen;
  int unsigned stall_left;

  int unsigned tokens_sent;
  int unsigned results_seen;
  int unsigned shown_count;
  int unsigned error_count;
  int unsigned mismatch_count;

  rpn_stack_calculator u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .push_value  (push_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .shown_value (shown_value)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one line per mismatch
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // exact floor division, rounding toward minus infinity, wrapping at 32 bits
  function automatic logic [DATA_W-1:0] floor_quotient(input logic [DATA_W-1:0] num,
                                                        input logic [DATA_W-1:0] den);
    longint a;
    longint b;
    longint q;
    a = $signed(num);
    b = $signed(den);
    q = a / b;
    if ((a % b) != 0 && ((a < 0) != (b < 0))) q = q - 1;
    return q[DATA_W-1:0];
  endfunction

  // apply one token to the predicted stack and return the result it owes
  function automatic calc_result_t predict_token(input logic [FUNC_W-1:0] f,
                                                 input logic [DATA_W-1:0] v);
    calc_result_t r;
    logic [DATA_W-1:0] top;
    logic [DATA_W-1:0] sec;
    logic bad;
    r.status = ST_DONE;
    r.value  = '0;
    bad = 1'b0;
    top = '0;
    sec = '0;
    if (calc_depth >= 1) top = calc_stack[calc_depth-1];
    if (calc_depth >= 2) sec = calc_stack[calc_depth-2];
    case (f)
      FN_PUSH, FN_DUP: begin
        if (calc_depth >= STACK_DEPTH_DEF || (f == FN_DUP && calc_depth < 1)) begin
          bad = 1'b1;
        end else begin
          calc_stack[calc_depth] = (f == FN_DUP) ? top : v;
          calc_depth++;
        end
      end
      FN_ADD, FN_SUB, FN_MUL, FN_DIV: begin
        if (calc_depth < 2 || (f == FN_DIV && top == '0)) begin
          bad = 1'b1;
        end else begin
          calc_depth--;
          case (f)
            FN_ADD:  calc_stack[calc_depth-1] = sec + top;
            FN_SUB:  calc_stack[calc_depth-1] = sec - top;
            FN_MUL:  calc_stack[calc_depth-1] = sec * top;
            default: calc_stack[calc_depth-1] = floor_quotient(sec, top);
          endcase
        end
      end
      FN_SWAP: begin
        if (calc_depth < 2) begin
          bad = 1'b1;
        end else begin
          calc_stack[calc_depth-1] = sec;
          calc_stack[calc_depth-2] = top;
        end
      end
      FN_EQ: begin
        if (calc_depth != 1) begin
          bad = 1'b1;
        end else begin
          r.status = ST_SHOWN;
          r.value  = calc_stack[0];
          calc_depth = 0;
          shown_count++;
        end
      end
      default: bad = 1'b1;
    endcase
    if (bad) begin
      calc_depth = 0;
      r.status = ST_ERROR;
      error_count++;
    end
    return r;
  endfunction

  // offer one item, called at a falling edge and returning at one
  task automatic send_token(input logic [FUNC_W-1:0] f, input logic [DATA_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    func       = f;
    push_value = v;
    do @(posedge clk); while (!in_ready);
    calc_expect.push_back(predict_token(f, v));
    tokens_sent++;
    @(negedge clk);
  endtask

  // stop offering and wait for every owed result
  task automatic wait_drained();
    in_valid = 1'b0;
    while (calc_expect.size() != 0) @(negedge clk);
  endtask

  // operand values biased toward the interesting corners
  function automatic logic [DATA_W-1:0] pick_value();
    logic [DATA_W-1:0] v;
    case ($urandom_range(4))
      0: v = DATA_W'(int'($urandom_range(40)) - 20);
      1: v = $urandom;
      2: begin
        case ($urandom_range(4))
          0: v = 32'h7fff_ffff;
          1: v = 32'h8000_0000;
          2: v = 32'h0000_0000;
          3: v = 32'hffff_ffff;
          default: v = 32'h0000_0001;
        endcase
      end
      3: begin
        v = 32'h1 << $urandom_range(31);
        if ($urandom_range(1)) v = -v;
      end
      default: v = DATA_W'($signed(16'($urandom)));
    endcase
    return v;
  endfunction

  // receiver: random stalls, plus a long hold-off when a test asks for one
  always @(negedge clk) begin
    if (stall_tag != stall_seen) begin
      stall_seen = stall_tag;
      stall_left = stall_len;
    end
    if (stall_left != 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else begin
      out_ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin : check_result
    calc_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (calc_expect.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: status %0d value %0d",
                                  status, shown_value));
      end else begin
        want = calc_expect[0];
        calc_expect.delete(0);
        results_seen++;
        if (status !== want.status)
          report_mismatch($sformatf("result %0d status: expected %0d got %0d",
                                    results_seen, want.status, status));
        if (shown_value !== want.value)
          report_mismatch($sformatf("result %0d value: expected %0d got %0d",
                                    results_seen, $signed(want.value), shown_value));
      end
    end
  end

  // operations on an empty or short stack
  task automatic test_short_stack();
    send_token(FN_EQ, 32'd0);
    send_token(FN_ADD, 32'd0);
    send_token(FN_DUP, 32'd0);
    send_token(FN_PUSH, 32'd5);
    send_token(FN_SWAP, 32'd0);
  endtask

  // wraparound at the extremes of the value range
  task automatic test_wraparound();
    send_token(FN_PUSH, 32'h7fff_ffff);
    send_token(FN_PUSH, 32'd1);
    send_token(FN_ADD, 32'hffff_ffff);
    send_token(FN_PUSH, 32'd1);
    send_token(FN_SUB, 32'h8000_0000);
    send_token(FN_PUSH, 32'hffff_ffff);
    send_token(FN_MUL, 32'd0);
    send_token(FN_EQ, 32'd0);
  endtask

  // floor rounding, the one overflowing quotient, and division by zero
  task automatic test_floor_division();
    send_token(FN_PUSH, -32'sd7);
    send_token(FN_PUSH, 32'd2);
    send_token(FN_DIV, 32'd0);
    send_token(FN_EQ, 32'd0);
    send_token(FN_PUSH, 32'h8000_0000);
    send_token(FN_PUSH, 32'hffff_ffff);
    send_token(FN_DIV, 32'd0);
    send_token(FN_EQ, 32'd0);
    send_token(FN_PUSH, 32'd3);
    send_token(FN_PUSH, 32'd0);
    send_token(FN_DIV, 32'd0);
  endtask

  // invalid tokens and equals with too many entries
  task automatic test_invalid_tokens();
    send_token(FN_BAD, 32'hffff_ffff);
    send_token(FN_BAD_LAST, 32'd0);
    send_token(FN_PUSH, 32'd1);
    send_token(FN_PUSH, 32'd2);
    send_token(FN_EQ, 32'd0);
  endtask

  // fill the stack to the bound: overflow by push and by dup, then fold it down
  task automatic test_full_stack();
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < STACK_DEPTH_DEF; i++) send_token(FN_PUSH, pick_value());
      case (k)
        0: send_token(FN_PUSH, pick_value());
        1: send_token(FN_DUP, 32'd0);
        default: begin
          for (int i = 1; i < STACK_DEPTH_DEF; i++) send_token(FN_ADD, 32'd0);
          send_token(FN_EQ, 32'd0);
        end
      endcase
    end
  endtask

  // mostly well-formed expressions with some noise tokens mixed in
  task automatic test_random_expressions(input int count);
    int unsigned r;
    logic [FUNC_W-1:0] f;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 5) begin
        f = FUNC_W'($urandom_range(15));
      end else if (calc_depth == 1 && r < 30) begin
        f = FN_EQ;
      end else if (calc_depth < 2) begin
        f = (r < 90) ? FN_PUSH : FN_DUP;
      end else if (calc_depth >= 12 || r >= 50) begin
        case ($urandom_range(5))
          0: f = FN_ADD;
          1: f = FN_SUB;
          2: f = FN_MUL;
          3: f = FN_DIV;
          4: f = FN_SWAP;
          default: f = FN_DUP;
        endcase
      end else begin
        f = FN_PUSH;
      end
      send_token(f, pick_value());
    end
  endtask

  // long output stall while items keep coming, then a pause until drained
  task automatic test_backpressure();
    stall_len = 300;
    stall_tag++;
    test_random_expressions(40);
    wait_drained();
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    func = FN_PUSH;
    push_value = '0;
    out_ready = 1'b0;
    calc_depth = 0;
    stall_len = 0;
    stall_tag = 0;
    stall_seen = 0;
    stall_left = 0;
    tokens_sent = 0;
    results_seen = 0;
    shown_count = 0;
    error_count = 0;
    mismatch_count = 0;
    send_idle_pct = 31;
    recv_idle_pct = 51;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_short_stack();
    test_wraparound();
    test_floor_division();
    test_invalid_tokens();
    test_full_stack();
    test_random_expressions(600);
    wait_drained();

    send_idle_pct = 51;
    recv_idle_pct = 31;
    test_random_expressions(600);
    test_backpressure();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_expressions(400);
    wait_drained();

    // let any stray result show up before the verdict
    repeat (60) @(posedge clk);
    foreach (calc_expect[i])
      report_mismatch($sformatf("expected status %0d never arrived", calc_expect[i].status));
    $display("ran %0d tokens through push, arithmetic, swap, dup and equals", tokens_sent);
    $display("%0d values shown, %0d error clears, full-stack and long output stall covered",
             shown_count, error_count);
    if (mismatch_count == 0) begin
      $display("rpn_stack_calculator: match");
    end else begin
      $display("rpn_stack_calculator: mismatch");
    end
    $finish;
  end

  // hard stop if the block hangs
  initial begin
    #(LIMIT_NS);
    $display("timeout with %0d results outstanding", calc_expect.size());
    $display("rpn_stack_calculator: mismatch");
    $finish;
  end

endmodule
